/* rtl/dss_seq_pkg.sv */
`timescale 1ns / 1ps

package dss_seq_pkg;

    // angle limit applied to every goal and direct value
    localparam logic [7:0] ANGLE_MAX = 8'd180;

    // item kinds
    localparam logic [2:0] KIND_TICK       = 3'd0;
    localparam logic [2:0] KIND_ARM        = 3'd1;
    localparam logic [2:0] KIND_FIRE_BOTH  = 3'd2;
    localparam logic [2:0] KIND_FIRE_LEFT  = 3'd3;
    localparam logic [2:0] KIND_FIRE_RIGHT = 3'd4;
    localparam logic [2:0] KIND_REST       = 3'd5;
    localparam logic [2:0] KIND_DIRECT     = 3'd6;
    // unused kind, ignored and never flagged
    localparam logic [2:0] KIND_SPARE      = 3'd7;

    // sequence phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MOVE = 2'd1;
    localparam logic [1:0] PH_HOLD = 2'd2;
    localparam logic [1:0] PH_BACK = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_STEP_SIZE   = 3'd0;
    localparam logic [2:0] REG_HOLD_TICKS  = 3'd1;
    localparam logic [2:0] REG_LEFT_REST   = 3'd2;
    localparam logic [2:0] REG_RIGHT_REST  = 3'd3;
    localparam logic [2:0] REG_LEFT_ARMED  = 3'd4;
    localparam logic [2:0] REG_RIGHT_ARMED = 3'd5;
    localparam logic [2:0] REG_LEFT_FIRED  = 3'd6;
    localparam logic [2:0] REG_RIGHT_FIRED = 3'd7;

    // reset values
    localparam logic [7:0]  RST_STEP_SIZE  = 8'd1;
    localparam logic [15:0] RST_HOLD_TICKS = 16'd10;
    localparam logic [7:0]  RST_ANGLE      = 8'd90;

    typedef struct packed {
        logic [7:0]  lpos;
        logic [7:0]  rpos;
        logic [7:0]  lgoal;
        logic [7:0]  rgoal;
        logic [1:0]  phase;
        logic [15:0] hold_cnt;
        logic        ret_after;
    } t_seq;

    function automatic logic [7:0] clamp_angle(input logic [7:0] a);
        return (a > ANGLE_MAX) ? ANGLE_MAX : a;
    endfunction

    // one slew step toward the goal, landing exactly on it
    function automatic logic [7:0] step_toward(input logic [7:0] pos,
                                               input logic [7:0] goal,
                                               input logic [7:0] step);
        logic [7:0] res;
        res = pos;
        if (pos < goal) begin
            res = ((goal - pos) > step) ? pos + step : goal;
        end else if (pos > goal) begin
            res = ((pos - goal) > step) ? pos - step : goal;
        end
        return res;
    endfunction

    // head back to rest, or go idle if already there
    function automatic t_seq begin_return(input t_seq st,
                                          input logic [7:0] lrest,
                                          input logic [7:0] rrest);
        t_seq s;
        s       = st;
        s.lgoal = clamp_angle(lrest);
        s.rgoal = clamp_angle(rrest);
        s.phase = (s.lpos == s.lgoal && s.rpos == s.rgoal) ? PH_IDLE : PH_BACK;
        return s;
    endfunction

    // both angles reached their goals
    function automatic t_seq arrive(input t_seq st,
                                    input logic [15:0] hold,
                                    input logic [7:0] lrest,
                                    input logic [7:0] rrest);
        t_seq s;
        s = st;
        if (st.phase == PH_MOVE && st.ret_after) begin
            s.ret_after = 1'b0;
            if (hold == 16'd0) begin
                s = begin_return(s, lrest, rrest);
            end else begin
                s.phase    = PH_HOLD;
                s.hold_cnt = hold;
            end
        end else begin
            s.ret_after = 1'b0;
            s.phase     = PH_IDLE;
        end
        return s;
    endfunction

    // load new goals and start moving
    function automatic t_seq start_move(input t_seq st,
                                        input logic [7:0] lg,
                                        input logic [7:0] rg,
                                        input logic fire,
                                        input logic [15:0] hold,
                                        input logic [7:0] lrest,
                                        input logic [7:0] rrest);
        t_seq s;
        s           = st;
        s.lgoal     = clamp_angle(lg);
        s.rgoal     = clamp_angle(rg);
        s.ret_after = fire;
        s.phase     = PH_MOVE;
        if (s.lpos == s.lgoal && s.rpos == s.rgoal) begin
            s = arrive(s, hold, lrest, rrest);
        end
        return s;
    endfunction

endpackage

/* rtl/dual_servo_slew_sequencer_core.sv */
`timescale 1ns / 1ps

// channel   direction  beat contents
// ------    ---------  ----------------------------------------------
// in        sink       i_kind, i_left_value, i_right_value
// out       source     o_left_angle, o_right_angle, o_phase, o_rejected
// cfg       sink       i_cfg_index, i_cfg_data (always ready)
//
// one input beat per cycle while in is ready; its result is registered and shows in the next cycle
// every beat is handled by combinational compare and add logic on the state
// the result register holds while the out channel stalls; in is ready whenever
// that register is empty or being drained in the same cycle
// synchronous active-low reset restores the default registers, angles 90, idle

module dual_servo_slew_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_left_value,
    input  logic [7:0]  i_right_value,
    // result beats
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_left_angle,
    output logic [7:0]  o_right_angle,
    output logic [1:0]  o_phase,
    output logic        o_rejected,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration registers
    logic [7:0]  r_step_size;
    logic [15:0] r_hold_ticks;
    logic [7:0]  r_left_rest;
    logic [7:0]  r_right_rest;
    logic [7:0]  r_left_armed;
    logic [7:0]  r_right_armed;
    logic [7:0]  r_left_fired;
    logic [7:0]  r_right_fired;

    // sequencer state
    dss_seq_pkg::t_seq r_st;
    dss_seq_pkg::t_seq n_st;
    logic              n_rej;

    // result register
    logic       r_out_valid;
    logic [7:0] r_left_angle;
    logic [7:0] r_right_angle;
    logic [1:0] r_phase;
    logic       r_rejected;

    logic       in_fire;
    logic [7:0] step_eff;
    logic [7:0] left_step;
    logic [7:0] right_step;

    assign o_ready     = !r_out_valid || i_ready;
    assign in_fire     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign o_valid       = r_out_valid;
    assign o_left_angle  = r_left_angle;
    assign o_right_angle = r_right_angle;
    assign o_phase       = r_phase;
    assign o_rejected    = r_rejected;

    // slew step, zero treated as one
    assign step_eff   = (r_step_size == 8'd0) ? 8'd1 : r_step_size;
    assign left_step  = dss_seq_pkg::step_toward(r_st.lpos, r_st.lgoal, step_eff);
    assign right_step = dss_seq_pkg::step_toward(r_st.rpos, r_st.rgoal, step_eff);

    // next state for the beat being taken
    always_comb begin
        n_st  = r_st;
        n_rej = 1'b0;
        if (i_kind == dss_seq_pkg::KIND_TICK) begin
            if (r_st.phase == dss_seq_pkg::PH_MOVE || r_st.phase == dss_seq_pkg::PH_BACK) begin
                n_st.lpos = left_step;
                n_st.rpos = right_step;
                if (left_step == r_st.lgoal && right_step == r_st.rgoal) begin
                    n_st = dss_seq_pkg::arrive(n_st, r_hold_ticks, r_left_rest, r_right_rest);
                end
            end else if (r_st.phase == dss_seq_pkg::PH_HOLD) begin
                if (r_st.hold_cnt <= 16'd1) begin
                    n_st.hold_cnt = 16'd0;
                    n_st = dss_seq_pkg::begin_return(n_st, r_left_rest, r_right_rest);
                end else begin
                    n_st.hold_cnt = r_st.hold_cnt - 16'd1;
                end
            end
        end else if (i_kind != dss_seq_pkg::KIND_SPARE) begin
            if (r_st.phase != dss_seq_pkg::PH_IDLE) begin
                n_rej = 1'b1;
            end else begin
                case (i_kind)
                    dss_seq_pkg::KIND_ARM: begin
                        n_st = dss_seq_pkg::start_move(r_st, r_left_armed, r_right_armed,
                            1'b0, r_hold_ticks, r_left_rest, r_right_rest);
                    end
                    dss_seq_pkg::KIND_FIRE_BOTH: begin
                        n_st = dss_seq_pkg::start_move(r_st, r_left_fired, r_right_fired,
                            1'b1, r_hold_ticks, r_left_rest, r_right_rest);
                    end
                    dss_seq_pkg::KIND_FIRE_LEFT: begin
                        n_st = dss_seq_pkg::start_move(r_st, r_left_fired, r_st.rpos,
                            1'b1, r_hold_ticks, r_left_rest, r_right_rest);
                    end
                    dss_seq_pkg::KIND_FIRE_RIGHT: begin
                        n_st = dss_seq_pkg::start_move(r_st, r_st.lpos, r_right_fired,
                            1'b1, r_hold_ticks, r_left_rest, r_right_rest);
                    end
                    dss_seq_pkg::KIND_REST: begin
                        n_st = dss_seq_pkg::start_move(r_st, r_left_rest, r_right_rest,
                            1'b0, r_hold_ticks, r_left_rest, r_right_rest);
                    end
                    dss_seq_pkg::KIND_DIRECT: begin
                        n_st.lpos      = dss_seq_pkg::clamp_angle(i_left_value);
                        n_st.lgoal     = dss_seq_pkg::clamp_angle(i_left_value);
                        n_st.rpos      = dss_seq_pkg::clamp_angle(i_right_value);
                        n_st.rgoal     = dss_seq_pkg::clamp_angle(i_right_value);
                        n_st.ret_after = 1'b0;
                        n_st.phase     = dss_seq_pkg::PH_IDLE;
                    end
                    default: begin
                        n_st = r_st;
                    end
                endcase
            end
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.lpos      <= dss_seq_pkg::RST_ANGLE;
            r_st.rpos      <= dss_seq_pkg::RST_ANGLE;
            r_st.lgoal     <= dss_seq_pkg::RST_ANGLE;
            r_st.rgoal     <= dss_seq_pkg::RST_ANGLE;
            r_st.phase     <= dss_seq_pkg::PH_IDLE;
            r_st.hold_cnt  <= 16'd0;
            r_st.ret_after <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_left_angle  <= n_st.lpos;
            r_right_angle <= n_st.rpos;
            r_phase       <= n_st.phase;
            r_rejected    <= n_rej;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size   <= dss_seq_pkg::RST_STEP_SIZE;
            r_hold_ticks  <= dss_seq_pkg::RST_HOLD_TICKS;
            r_left_rest   <= dss_seq_pkg::RST_ANGLE;
            r_right_rest  <= dss_seq_pkg::RST_ANGLE;
            r_left_armed  <= dss_seq_pkg::RST_ANGLE;
            r_right_armed <= dss_seq_pkg::RST_ANGLE;
            r_left_fired  <= dss_seq_pkg::RST_ANGLE;
            r_right_fired <= dss_seq_pkg::RST_ANGLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dss_seq_pkg::REG_STEP_SIZE:   r_step_size   <= i_cfg_data[7:0];
                dss_seq_pkg::REG_HOLD_TICKS:  r_hold_ticks  <= i_cfg_data;
                dss_seq_pkg::REG_LEFT_REST:   r_left_rest   <= i_cfg_data[7:0];
                dss_seq_pkg::REG_RIGHT_REST:  r_right_rest  <= i_cfg_data[7:0];
                dss_seq_pkg::REG_LEFT_ARMED:  r_left_armed  <= i_cfg_data[7:0];
                dss_seq_pkg::REG_RIGHT_ARMED: r_right_armed <= i_cfg_data[7:0];
                dss_seq_pkg::REG_LEFT_FIRED:  r_left_fired  <= i_cfg_data[7:0];
                dss_seq_pkg::REG_RIGHT_FIRED: r_right_fired <= i_cfg_data[7:0];
                default: r_step_size <= r_step_size;
            endcase
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES   = 3;
    localparam int NUM_REGS        = 8;

    typedef struct packed {
        logic [7:0] left_angle;
        logic [7:0] right_angle;
        logic [1:0] phase;
        logic       rejected;
    } t_servo_status;

    // tracks both servos beat by beat and checks every result beat
    class slew_scoreboard;
        logic [7:0]    step_reg;
        logic [15:0]   hold_reg;
        logic [7:0]    left_rest_reg, right_rest_reg;
        logic [7:0]    left_armed_reg, right_armed_reg;
        logic [7:0]    left_fired_reg, right_fired_reg;
        logic [7:0]    left_pos, right_pos, left_goal, right_goal;
        logic [1:0]    phase;
        logic [15:0]   hold_left;
        logic          fire_pending;
        t_servo_status servo_status_q[$];
        int            errors, beats, checked, rejects, holds;

        function new();
            step_reg        = dss_seq_pkg::RST_STEP_SIZE;
            hold_reg        = dss_seq_pkg::RST_HOLD_TICKS;
            left_rest_reg   = dss_seq_pkg::RST_ANGLE;
            right_rest_reg  = dss_seq_pkg::RST_ANGLE;
            left_armed_reg  = dss_seq_pkg::RST_ANGLE;
            right_armed_reg = dss_seq_pkg::RST_ANGLE;
            left_fired_reg  = dss_seq_pkg::RST_ANGLE;
            right_fired_reg = dss_seq_pkg::RST_ANGLE;
            left_pos        = dss_seq_pkg::RST_ANGLE;
            right_pos       = dss_seq_pkg::RST_ANGLE;
            left_goal       = dss_seq_pkg::RST_ANGLE;
            right_goal      = dss_seq_pkg::RST_ANGLE;
            phase           = dss_seq_pkg::PH_IDLE;
            hold_left       = '0;
            fire_pending    = 1'b0;
            errors          = 0;
            beats           = 0;
            checked         = 0;
            rejects         = 0;
            holds           = 0;
        endfunction

        function int pending();
            return servo_status_q.size();
        endfunction

        function logic [7:0] limit(input logic [7:0] a);
            return (a > dss_seq_pkg::ANGLE_MAX) ? dss_seq_pkg::ANGLE_MAX : a;
        endfunction

        // move one stride toward the goal without overshooting it
        function logic [7:0] slew(input logic [7:0] pos, input logic [7:0] goal,
                                  input int stride);
            int p, g;
            p = pos;
            g = goal;
            if (p < g) begin
                p = (g - p > stride) ? p + stride : g;
            end else if (p > g) begin
                p = (p - g > stride) ? p - stride : g;
            end
            return p[7:0];
        endfunction

        function bit settled();
            return left_pos == left_goal && right_pos == right_goal;
        endfunction

        // aim at rest, already there means the sequence is over
        function void head_home();
            left_goal  = limit(left_rest_reg);
            right_goal = limit(right_rest_reg);
            phase      = settled() ? dss_seq_pkg::PH_IDLE : dss_seq_pkg::PH_BACK;
        endfunction

        // both sides on their goals: a fire goes on to hold (or home if the hold is zero), anything else ends
        function void reach_goal();
            if (phase == dss_seq_pkg::PH_MOVE && fire_pending) begin
                fire_pending = 1'b0;
                if (hold_reg == 16'd0) begin
                    head_home();
                end else begin
                    phase     = dss_seq_pkg::PH_HOLD;
                    hold_left = hold_reg;
                    holds++;
                end
            end else begin
                fire_pending = 1'b0;
                phase        = dss_seq_pkg::PH_IDLE;
            end
        endfunction

        function void load_goals(input logic [7:0] lg, input logic [7:0] rg,
                                 input logic fire);
            left_goal    = limit(lg);
            right_goal   = limit(rg);
            fire_pending = fire;
            phase        = dss_seq_pkg::PH_MOVE;
            if (settled()) begin
                reach_goal();
            end
        endfunction

        function void note_register(input logic [2:0] idx, input logic [15:0] data);
            case (idx)
                dss_seq_pkg::REG_STEP_SIZE:   step_reg        = data[7:0];
                dss_seq_pkg::REG_HOLD_TICKS:  hold_reg        = data;
                dss_seq_pkg::REG_LEFT_REST:   left_rest_reg   = data[7:0];
                dss_seq_pkg::REG_RIGHT_REST:  right_rest_reg  = data[7:0];
                dss_seq_pkg::REG_LEFT_ARMED:  left_armed_reg  = data[7:0];
                dss_seq_pkg::REG_RIGHT_ARMED: right_armed_reg = data[7:0];
                dss_seq_pkg::REG_LEFT_FIRED:  left_fired_reg  = data[7:0];
                dss_seq_pkg::REG_RIGHT_FIRED: right_fired_reg = data[7:0];
                default: ;
            endcase
        endfunction

        // apply one accepted beat and queue the status it should produce
        function void advance_servos(input logic [2:0] kind, input logic [7:0] lv,
                                     input logic [7:0] rv);
            t_servo_status want;
            logic          rej;
            int            stride;
            rej = 1'b0;
            if (kind == dss_seq_pkg::KIND_TICK) begin
                if (phase == dss_seq_pkg::PH_MOVE || phase == dss_seq_pkg::PH_BACK) begin
                    stride    = (step_reg == 8'd0) ? 1 : int'(step_reg);
                    left_pos  = slew(left_pos, left_goal, stride);
                    right_pos = slew(right_pos, right_goal, stride);
                    if (settled()) begin
                        reach_goal();
                    end
                end else if (phase == dss_seq_pkg::PH_HOLD) begin
                    if (hold_left != 16'd0) begin
                        hold_left = hold_left - 16'd1;
                    end
                    if (hold_left == 16'd0) begin
                        head_home();
                    end
                end
            end else if (kind != dss_seq_pkg::KIND_SPARE) begin
                if (phase != dss_seq_pkg::PH_IDLE) begin
                    rej = 1'b1;
                    rejects++;
                end else begin
                    case (kind)
                        dss_seq_pkg::KIND_ARM:
                            load_goals(left_armed_reg, right_armed_reg, 1'b0);
                        dss_seq_pkg::KIND_FIRE_BOTH:
                            load_goals(left_fired_reg, right_fired_reg, 1'b1);
                        dss_seq_pkg::KIND_FIRE_LEFT:
                            load_goals(left_fired_reg, right_pos, 1'b1);
                        dss_seq_pkg::KIND_FIRE_RIGHT:
                            load_goals(left_pos, right_fired_reg, 1'b1);
                        dss_seq_pkg::KIND_REST:
                            load_goals(left_rest_reg, right_rest_reg, 1'b0);
                        dss_seq_pkg::KIND_DIRECT: begin
                            left_pos     = limit(lv);
                            right_pos    = limit(rv);
                            left_goal    = left_pos;
                            right_goal   = right_pos;
                            fire_pending = 1'b0;
                            phase        = dss_seq_pkg::PH_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
            want.left_angle  = left_pos;
            want.right_angle = right_pos;
            want.phase       = phase;
            want.rejected    = rej;
            servo_status_q.push_back(want);
            beats++;
        endfunction

        function void compare_field(input string field, input int want, input int got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_servo_status(input logic [7:0] la, input logic [7:0] ra,
                                         input logic [1:0] ph, input logic rej);
            t_servo_status want;
            if (servo_status_q.size() == 0) begin
                $display("%0t ns: unexpected result beat, expected none, actual %0d %0d %0d %0d",
                         $time, la, ra, ph, rej);
                errors++;
                return;
            end
            want = servo_status_q.pop_front();
            checked++;
            compare_field("left_angle", want.left_angle, la);
            compare_field("right_angle", want.right_angle, ra);
            compare_field("phase", want.phase, ph);
            compare_field("rejected", want.rejected, rej);
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [2:0]  i_kind        = dss_seq_pkg::KIND_TICK;
    logic [7:0]  i_left_value  = 8'd0;
    logic [7:0]  i_right_value = 8'd0;
    logic        i_ready       = 1'b1;
    logic        i_cfg_valid   = 1'b0;
    logic [2:0]  i_cfg_index   = dss_seq_pkg::REG_STEP_SIZE;
    logic [15:0] i_cfg_data    = 16'd0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_left_angle;
    logic [7:0]  o_right_angle;
    logic [1:0]  o_phase;
    logic        o_rejected;
    logic        o_cfg_ready;

    slew_scoreboard sb;
    int cycles     = 0;
    int idle_odds  = 6;
    int stall_left = 0;
    int settings   = 0;
    bit quiet      = 1'b0;

    dual_servo_slew_sequencer_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            stall_left <= 0;
            i_ready    <= 1'b1;
        end else if (stall_left == 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left <= $urandom_range(1, 9);
            i_ready    <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else begin
            stall_left <= 0;
            i_ready    <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_servo_status(o_left_angle, o_right_angle, o_phase, o_rejected);
        end
    end

    function automatic logic [15:0] random_angle();
        logic [7:0] a;
        a = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(181, 255))
                                        : 8'($urandom_range(0, 180));
        return {8'($urandom_range(0, 255)), a};
    endfunction

    // one input beat, with an optional gap in front of it
    task automatic send_item(input logic [2:0] kind, input logic [7:0] lv,
                             input logic [7:0] rv);
        if (!quiet && $urandom_range(1, idle_odds) == 1) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_left_value  <= lv;
        i_right_value <= rv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.advance_servos(kind, lv, rv);
    endtask

    // drain the pipeline, then write every register
    task automatic write_config(input logic [15:0] step_d, input logic [15:0] hold_d,
                                input logic [15:0] lr, input logic [15:0] rr,
                                input logic [15:0] la, input logic [15:0] ra,
                                input logic [15:0] lf, input logic [15:0] rf);
        logic [15:0] values [NUM_REGS];
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        values[dss_seq_pkg::REG_STEP_SIZE]   = step_d;
        values[dss_seq_pkg::REG_HOLD_TICKS]  = hold_d;
        values[dss_seq_pkg::REG_LEFT_REST]   = lr;
        values[dss_seq_pkg::REG_RIGHT_REST]  = rr;
        values[dss_seq_pkg::REG_LEFT_ARMED]  = la;
        values[dss_seq_pkg::REG_RIGHT_ARMED] = ra;
        values[dss_seq_pkg::REG_LEFT_FIRED]  = lf;
        values[dss_seq_pkg::REG_RIGHT_FIRED] = rf;
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_data  <= values[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.note_register(i[2:0], values[i]);
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [15:0] step_d;
        logic [15:0] hold_d;
        logic [2:0]  kind;
        int          pick;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: idle tick, spare kind, arm already at goal
        send_item(dss_seq_pkg::KIND_TICK, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_SPARE, 8'hff, 8'hff);
        send_item(dss_seq_pkg::KIND_ARM, 8'h55, 8'haa);
        // fire with goals already reached goes straight to hold
        send_item(dss_seq_pkg::KIND_FIRE_BOTH, 8'haa, 8'h55);
        // every command while holding is turned away
        send_item(dss_seq_pkg::KIND_ARM, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_FIRE_BOTH, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_FIRE_LEFT, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_FIRE_RIGHT, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_REST, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_DIRECT, 8'd10, 8'd10);
        // hold runs out while at rest, so the block goes idle
        repeat (dss_seq_pkg::RST_HOLD_TICKS) begin
            send_item(dss_seq_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
        end
        // direct writes with clamping
        send_item(dss_seq_pkg::KIND_DIRECT, 8'd255, 8'd0);
        send_item(dss_seq_pkg::KIND_DIRECT, 8'd181, 8'd180);
        send_item(dss_seq_pkg::KIND_DIRECT, 8'd179, 8'd1);

        // zero step, zero hold, rest above the limit, upper data bits set
        write_config(16'hff00, 16'd0, 16'hffff, 16'h0000,
                     16'h0000, 16'h00b4, 16'hffb4, 16'hff00);
        send_item(dss_seq_pkg::KIND_FIRE_BOTH, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_TICK, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_FIRE_LEFT, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_FIRE_RIGHT, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_REST, 8'd0, 8'd0);

        // widest step and a longer hold, run to the end without gaps
        write_config(16'd180, 16'd24, 16'd90, 16'd90,
                     16'd0, 16'd255, 16'd180, 16'd0);
        send_item(dss_seq_pkg::KIND_ARM, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_TICK, 8'd0, 8'd0);
        send_item(dss_seq_pkg::KIND_FIRE_BOTH, 8'd0, 8'd0);
        quiet = 1'b1;
        while (sb.phase != dss_seq_pkg::PH_IDLE) begin
            send_item(dss_seq_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
        end
        quiet = 1'b0;

        // random settings, mostly command/tick sequences with some noise
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       step_d = 16'd0;
                1:       step_d = 16'd180;
                2:       step_d = 16'd255;
                3:       step_d = 16'($urandom_range(0, 255));
                default: step_d = 16'($urandom_range(1, 12));
            endcase
            step_d[15:8] = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0:       hold_d = 16'd0;
                1:       hold_d = 16'($urandom_range(1, 3));
                default: hold_d = 16'($urandom_range(4, 25));
            endcase
            write_config(step_d, hold_d, random_angle(), random_angle(),
                         random_angle(), random_angle(), random_angle(), random_angle());
            case ($urandom_range(0, 2))
                0:       idle_odds = 3;
                1:       idle_odds = 6;
                default: idle_odds = 25;
            endcase
            quiet = (ph == RANDOM_PHASES - 1);
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (sb.phase == dss_seq_pkg::PH_IDLE) begin
                    kind = (pick < 25) ? dss_seq_pkg::KIND_TICK :
                           (pick < 30) ? dss_seq_pkg::KIND_SPARE :
                           3'($urandom_range(dss_seq_pkg::KIND_ARM, dss_seq_pkg::KIND_DIRECT));
                end else begin
                    kind = (pick < 85) ? dss_seq_pkg::KIND_TICK :
                           (pick < 88) ? dss_seq_pkg::KIND_SPARE :
                           3'($urandom_range(dss_seq_pkg::KIND_ARM, dss_seq_pkg::KIND_DIRECT));
                end
                send_item(kind, 8'($urandom), 8'($urandom));
            end
        end

        // let every outstanding result arrive
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES + 5) @(posedge i_clk);
        $display("run summary: %0d beats in, %0d results checked, %0d busy commands refused",
                 sb.beats, sb.checked, sb.rejects);
        $display("run summary: %0d fire holds entered over %0d register settings",
                 sb.holds, settings);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
